@@ design/pitch_run_median_octave_fold_macros.svh @@
// assertion macros for the pitch run median smoother
`ifndef PITCH_RUN_MEDIAN_OCTAVE_FOLD_MACROS_SVH
`define PITCH_RUN_MEDIAN_OCTAVE_FOLD_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is asserted
`define PMOF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled while reset is asserted
`define PMOF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PMOF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define PMOF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ design/pmof_pkg.sv @@
// shared types, constants and codes of the pitch run median smoother
`default_nettype none
package pmof_pkg;

    // field widths
    localparam int PITCH_W   = 15;
    localparam int TONE_W    = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 15;

    // window size
    localparam int HALF_WINDOW_DEF = 4;
    localparam int HALF_WINDOW_MAX = 7;
    localparam int CNT_W           = $clog2(2 * HALF_WINDOW_MAX + 2);

    // job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // octave folding, pitch in 1/256 semitone
    localparam int OCTAVE_UNITS = 3072;
    localparam int FOLD_LIMIT   = 768;
    localparam int FOLD_BIAS    = OCTAVE_UNITS / 2 + 12 * OCTAVE_UNITS;
    localparam int RECIP_3      = 171;
    localparam int RECIP_SHIFT  = 9;
    localparam int REL_W        = 13;
    localparam int PITCH_MAX    = (1 << PITCH_W) - 1;

    // tuning class limits on |deviation| in 1/256 semitone
    localparam int GOOD_DEV = 30;
    localparam int WARN_DEV = 102;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOLD_EN  = 1'd1;

    // job kinds handed from front to back
    typedef enum logic [1:0] {
        OP_SHIFT,
        OP_EMIT,
        OP_FLUSH
    } op_t;

    typedef enum logic [TONE_W-1:0] {
        TONE_FINE = 2'd0,
        TONE_NEAR = 2'd1,
        TONE_OFF  = 2'd2
    } tone_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FOLD,
        ST_EMIT
    } back_state_t;

    typedef struct packed {
        op_t                op;
        logic [PITCH_W-1:0] pitch;
        logic [CNT_W-1:0]   cnt;   // frames to flush
        logic [CNT_W-1:0]   rc;    // frames held in the run
    } job_t;

endpackage
`default_nettype wire

@@ design/pitch_run_median_octave_fold.sv @@
// top level of the pitch run median smoother with octave folding
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  s_tdata[14:0] pitch, s_tuser voiced
//   m_       out  m_tvalid/m_tready  m_tdata[14:0] smoothed_pitch,
//                                    m_tuser tone_class, m_tlast last_of_burst
//   cfg_     in   cfg_we             cfg_index, cfg_wdata
//
// a frame is taken while the two-entry job queue has room.
// a frame without a result only shifts the back end window; a result of a job
// is found by the rank scan over hi+1 window entries, hi+1 being at most the
// window size (2*HALF_WINDOW+1, 9 by default); the scan tests one median
// candidate per cycle, and the median then passes the fold and result register.
// synchronous active-low reset clears counters, queue, sequencer and config.
// a stalled m_ side holds the result; the front keeps taking frames until
// the queue is full.
`default_nettype none
`include "pitch_run_median_octave_fold_macros.svh"
module pitch_run_median_octave_fold #(
    parameter int HALF_WINDOW = pmof_pkg::HALF_WINDOW_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire [pmof_pkg::S_TDATA_W-1:0]  s_tdata,   // [14:0] pitch, [15] zero
    input  wire                            s_tuser,   // [0] voiced
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [pmof_pkg::M_TDATA_W-1:0] m_tdata,   // [14:0] smoothed_pitch, [15] zero
    output logic [pmof_pkg::TONE_W-1:0]    m_tuser,   // [1:0] tone_class
    output logic                           m_tlast,   // last_of_burst
    input  wire                            cfg_we,
    input  wire [pmof_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [pmof_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
    import pmof_pkg::*;

    logic q_push, q_full, q_empty, q_pop;
    job_t push_job, head_job;

    pmof_front #(
        .HALF_WINDOW (HALF_WINDOW)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    pmof_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .empty    (q_empty),
        .pop      (q_pop),
        .head_job (head_job)
    );

    pmof_back #(
        .HALF_WINDOW (HALF_WINDOW)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_empty   (q_empty),
        .q_head    (head_job),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // queue never overflows or underflows, jobs come only from taken frames
    `PMOF_ASSERT_IMPL(a_push_room, aclk, aresetn, q_push, !q_full, "job pushed into full queue")
    `PMOF_ASSERT_IMPL(a_pop_data, aclk, aresetn, q_pop, !q_empty, "job popped from empty queue")
    `PMOF_ASSERT_IMPL(a_push_src, aclk, aresetn, q_push, s_tvalid && s_tready, "job without frame")
    `PMOF_ASSERT_NEXT(a_full_stall, aclk, aresetn, q_full && !q_pop, !s_tready, "full queue not stalling input")

endmodule
`default_nettype wire

@@ design/pmof_front.sv @@
// front end: accepts frames, tracks run and pending counts, issues jobs
`default_nettype none
module pmof_front #(
    parameter int HALF_WINDOW = pmof_pkg::HALF_WINDOW_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire [pmof_pkg::S_TDATA_W-1:0]  s_tdata,   // [14:0] pitch, [15] zero
    input  wire                            s_tuser,   // [0] voiced
    input  wire                            q_full,
    output logic                           q_push,
    output pmof_pkg::job_t                 q_job
);
    import pmof_pkg::*;

    localparam int WIN = 2 * HALF_WINDOW + 1;
    localparam int CW  = $clog2(WIN + 1);
    localparam int AW  = $clog2(HALF_WINDOW + 1);

    logic [CW-1:0] rc_reg, rc_next;
    logic [AW-1:0] pend_reg, pend_next;
    logic          xfer;

    assign s_tready = !q_full;
    assign xfer     = s_tvalid && s_tready;

    // classify the frame and update the counters
    always_comb begin
        rc_next     = rc_reg;
        pend_next   = pend_reg;
        q_push      = 1'b0;
        q_job.op    = OP_SHIFT;
        q_job.pitch = s_tdata[PITCH_W-1:0];
        q_job.cnt   = CNT_W'(pend_reg);
        q_job.rc    = CNT_W'(rc_reg);
        if (xfer) begin
            if (s_tuser) begin
                if (rc_reg != CW'(WIN)) begin
                    rc_next = rc_reg + 1'b1;
                end
                q_job.rc = CNT_W'(rc_next);
                q_push   = 1'b1;
                if (pend_reg == AW'(HALF_WINDOW)) begin
                    q_job.op = OP_EMIT;
                end else begin
                    q_job.op  = OP_SHIFT;
                    pend_next = pend_reg + 1'b1;
                end
            end else begin
                // unvoiced frame: flush what is pending, restart the run
                q_job.op  = OP_FLUSH;
                q_push    = (pend_reg != '0);
                rc_next   = '0;
                pend_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rc_reg   <= '0;
            pend_reg <= '0;
        end else begin
            rc_reg   <= rc_next;
            pend_reg <= pend_next;
        end
    end

endmodule
`default_nettype wire

@@ design/pmof_queue.sv @@
// short job queue between front end and back end
`default_nettype none
module pmof_queue (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             push,
    input  pmof_pkg::job_t  push_job,
    output logic            full,
    output logic            empty,
    input  wire             pop,
    output pmof_pkg::job_t  head_job
);
    import pmof_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full     = (count_reg == CNT_QW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

@@ design/pmof_back.sv @@
// back end: frame window, rank-scan median, octave fold and result register
`default_nettype none
module pmof_back #(
    parameter int HALF_WINDOW = pmof_pkg::HALF_WINDOW_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            cfg_we,
    input  wire [pmof_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [pmof_pkg::CFG_DAT_W-1:0]  cfg_wdata,
    input  wire                            q_empty,
    input  pmof_pkg::job_t                 q_head,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [pmof_pkg::M_TDATA_W-1:0] m_tdata,   // [14:0] smoothed_pitch, [15] zero
    output logic [pmof_pkg::TONE_W-1:0]    m_tuser,   // [1:0] tone_class
    output logic                           m_tlast    // last_of_burst
);
    import pmof_pkg::*;

    localparam int WIN = 2 * HALF_WINDOW + 1;
    localparam int CW  = $clog2(WIN + 1);
    localparam int AW  = $clog2(HALF_WINDOW + 1);
    localparam int IW  = $clog2(WIN);

    // highest window age used by the median centred on the given age
    function automatic logic [IW-1:0] hi_of(input logic [AW-1:0] age,
                                            input logic [CW-1:0] rc);
        logic [CW-1:0] reach;
        logic [CW-1:0] top;
        reach = CW'(age) + CW'(HALF_WINDOW);
        top   = rc - 1'b1;
        return (reach < top) ? IW'(reach) : IW'(top);
    endfunction

    // configuration registers
    logic [PITCH_W-1:0] base_reg;
    logic               fold_en_reg;

    // frame window, newest first
    logic [PITCH_W-1:0] win_reg [WIN];
    logic               win_shift;

    back_state_t         state_reg, state_next;
    logic [AW-1:0]       age_reg, age_next;
    logic [CW-1:0]       rc_reg, rc_next;
    logic [IW-1:0]       hi_reg, hi_next;
    logic [IW-1:0]       cand_reg, cand_next;
    logic                flush_reg, flush_next;
    logic [PITCH_W-1:0]  med_reg, med_next;
    logic signed [REL_W-1:0] rel_reg, rel_next;
    logic                fold_ok_reg, fold_ok_next;
    logic                m_valid_reg, m_valid_next;
    logic [PITCH_W-1:0]  m_pitch_reg, m_pitch_next;
    logic [TONE_W-1:0]   m_tone_reg, m_tone_next;
    logic                m_last_reg, m_last_next;

    // rank of the candidate inside the window
    logic [PITCH_W-1:0] cand_val;
    logic [CW-1:0]      rank;
    logic [CW-1:0]      target;

    assign cand_val = win_reg[cand_reg];
    assign target   = (CW'(hi_reg) + 1'b1) >> 1;

    always_comb begin
        rank = '0;
        for (int j = 0; j < WIN; j++) begin
            if ((IW'(j) <= hi_reg) &&
                ((win_reg[j] < cand_val) ||
                 ((win_reg[j] == cand_val) && (IW'(j) < cand_reg)))) begin
                rank = rank + 1'b1;
            end
        end
    end

    // fold, first half: distance to the baseline pitch class
    logic signed [17:0]     diff;
    logic signed [17:0]     biased;
    logic [6:0]             oct_hi;
    logic [14:0]            quot_prod;
    logic [5:0]             quot;
    logic [6:0]             oct_mod;
    logic [11:0]            in_oct;
    logic signed [REL_W-1:0] rel_calc;

    assign diff      = $signed({3'b000, med_reg}) - $signed({3'b000, base_reg});
    assign biased    = diff + 18'(FOLD_BIAS);
    assign oct_hi    = biased[16:10];
    assign quot_prod = 15'(oct_hi) * 15'(RECIP_3);
    assign quot      = quot_prod[14:RECIP_SHIFT];
    assign oct_mod   = oct_hi - 7'(quot) * 7'd3;
    assign in_oct    = {oct_mod[1:0], biased[9:0]};
    assign rel_calc  = $signed({1'b0, in_oct}) - REL_W'(OCTAVE_UNITS / 2);

    // fold, second half: move into the baseline octave and saturate
    logic signed [16:0]  moved;
    logic [PITCH_W-1:0]  clamped;
    logic [PITCH_W-1:0]  result;
    logic signed [7:0]   dev;
    logic [7:0]          dev_mag;
    logic [TONE_W-1:0]   tone;

    assign moved = $signed({2'b00, base_reg}) + 17'(rel_reg);

    always_comb begin
        if (moved < 0) begin
            clamped = '0;
        end else if (moved > 17'(PITCH_MAX)) begin
            clamped = PITCH_W'(PITCH_MAX);
        end else begin
            clamped = moved[PITCH_W-1:0];
        end
    end

    assign result  = fold_ok_reg ? clamped : med_reg;
    assign dev     = $signed(result[7:0]);
    assign dev_mag = dev[7] ? 8'(-dev) : 8'(dev);

    // tuning class
    always_comb begin
        if (dev_mag <= 8'(GOOD_DEV)) begin
            tone = TONE_FINE;
        end else if (dev_mag <= 8'(WARN_DEV)) begin
            tone = TONE_NEAR;
        end else begin
            tone = TONE_OFF;
        end
    end

    // sequencer: pop job, scan ranks, fold, hand over the result
    always_comb begin
        state_next   = state_reg;
        age_next     = age_reg;
        rc_next      = rc_reg;
        hi_next      = hi_reg;
        cand_next    = cand_reg;
        flush_next   = flush_reg;
        med_next     = med_reg;
        rel_next     = rel_reg;
        fold_ok_next = fold_ok_reg;
        m_valid_next = m_valid_reg;
        m_pitch_next = m_pitch_reg;
        m_tone_next  = m_tone_reg;
        m_last_next  = m_last_reg;
        q_pop        = 1'b0;
        win_shift    = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop     = 1'b1;
                    rc_next   = q_head.rc[CW-1:0];
                    cand_next = '0;
                    case (q_head.op)
                        OP_SHIFT: begin
                            win_shift = 1'b1;
                        end
                        OP_EMIT: begin
                            win_shift  = 1'b1;
                            flush_next = 1'b0;
                            age_next   = AW'(HALF_WINDOW);
                            hi_next    = hi_of(AW'(HALF_WINDOW), q_head.rc[CW-1:0]);
                            state_next = ST_SCAN;
                        end
                        OP_FLUSH: begin
                            flush_next = 1'b1;
                            age_next   = AW'(q_head.cnt - 1'b1);
                            hi_next    = hi_of(AW'(q_head.cnt - 1'b1), q_head.rc[CW-1:0]);
                            state_next = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (rank == target) begin
                    med_next   = cand_val;
                    state_next = ST_FOLD;
                end else begin
                    cand_next = cand_reg + 1'b1;
                end
            end
            ST_FOLD: begin
                rel_next     = rel_calc;
                fold_ok_next = fold_en_reg &&
                               (rel_calc > -REL_W'(FOLD_LIMIT)) &&
                               (rel_calc < REL_W'(FOLD_LIMIT));
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_pitch_next = result;
                    m_tone_next  = tone;
                    m_last_next  = !flush_reg || (age_reg == '0);
                    if (flush_reg && (age_reg != '0)) begin
                        age_next   = age_reg - 1'b1;
                        hi_next    = hi_of(age_reg - 1'b1, rc_reg);
                        cand_next  = '0;
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working and result payload
    always_ff @(posedge aclk) begin
        age_reg     <= age_next;
        rc_reg      <= rc_next;
        hi_reg      <= hi_next;
        cand_reg    <= cand_next;
        flush_reg   <= flush_next;
        med_reg     <= med_next;
        rel_reg     <= rel_next;
        fold_ok_reg <= fold_ok_next;
        m_pitch_reg <= m_pitch_next;
        m_tone_reg  <= m_tone_next;
        m_last_reg  <= m_last_next;
    end

    // window shift
    always_ff @(posedge aclk) begin
        if (win_shift) begin
            win_reg[0] <= q_head.pitch;
            for (int i = 1; i < WIN; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= '0;
            fold_en_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BASELINE: base_reg    <= cfg_wdata[PITCH_W-1:0];
                REG_FOLD_EN:  fold_en_reg <= cfg_wdata[0];
                default: begin
                    base_reg <= base_reg;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_pitch_reg);
    assign m_tuser  = m_tone_reg;
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire
